[rtl/core/pva_pkg.sv]
// Shared constants, types and helpers of the polyphonic voice allocator.
package pva_pkg;

	localparam int VOICES       = 16;
	localparam int VIDX_W       = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int VCNT_W       = $clog2(VOICES + 1);
	localparam int STAMP_W      = 32;
	localparam int NOTE_W       = 7;
	localparam int VEL_W        = 7;
	localparam int VOICE_W      = 4;
	localparam int CFG_W        = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int ACTIVE_RESET = 16;
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W       = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MULTI   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd2;

	localparam logic CMD_NOTE_ON  = 1'b0;
	localparam logic CMD_NOTE_OFF = 1'b1;

	localparam logic KIND_DOWN = 1'b0;
	localparam logic KIND_UP   = 1'b1;

	typedef enum logic [1:0] {
		OP_ON,
		OP_OFF,
		OP_SINGLE_ON,
		OP_SINGLE_OFF
	} pva_op_t;

	typedef struct packed {
		pva_op_t             op;
		logic [NOTE_W-1:0]   note;
		logic [VEL_W-1:0]    velocity;
		logic [VCNT_W-1:0]   count;
	} pva_item_t;

	typedef struct packed {
		logic                event_kind;
		logic [VOICE_W-1:0]  voice;
		logic                single_voice;
		logic [NOTE_W-1:0]   note_out;
		logic [VEL_W-1:0]    velocity_out;
		logic                last;
	} pva_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_SCAN,
		ST_ON_EMIT,
		ST_MASK,
		ST_OFF_EMIT
	} pva_state_t;

	function automatic logic [VOICE_W-1:0] to_voice(input logic [VIDX_W-1:0] idx);
		logic [VIDX_W+VOICE_W-1:0] ext;
		ext = (VIDX_W + VOICE_W)'(idx);
		return ext[VOICE_W-1:0];
	endfunction

endpackage

[rtl/core/pva_front.sv]
// Front end: configuration registers, event classification and transaction queue.
module pva_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [pva_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pva_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [pva_pkg::NOTE_W-1:0]    note,
	input  logic [pva_pkg::VEL_W-1:0]     velocity,
	output logic                          item_valid,
	output pva_pkg::pva_item_t            item,
	input  logic                          item_pop
);
	import pva_pkg::*;

	logic              enabled_q;
	logic              multi_q;
	logic [CFG_W-1:0]  active_q;
	pva_item_t         q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              full;
	logic              push;
	logic              pop;
	pva_item_t         new_item;
	logic [VCNT_W-1:0] n_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
			multi_q   <= 1'b1;
			active_q  <= CFG_W'(ACTIVE_RESET);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ENABLED: enabled_q <= cfg_data[0];
				CFG_MULTI:   multi_q   <= cfg_data[0];
				CFG_ACTIVE:  active_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp the active count into 1..VOICES
	always_comb begin
		if (active_q == '0) begin
			n_act = VCNT_W'(1);
		end else if (32'(active_q) > VOICES) begin
			n_act = VCNT_W'(VOICES);
		end else begin
			n_act = VCNT_W'(active_q);
		end
	end

	always_comb begin
		new_item.note     = note;
		new_item.velocity = velocity;
		new_item.count    = n_act;
		if (multi_q) begin
			new_item.op = (command == CMD_NOTE_OFF) ? OP_OFF : OP_ON;
		end else begin
			new_item.op = (command == CMD_NOTE_OFF) ? OP_SINGLE_OFF : OP_SINGLE_ON;
		end
	end

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign in_stall   = full;
	// drop transactions while disabled
	assign push       = in_valid && !full && enabled_q;
	assign item_valid = (cnt_q != '0);
	assign pop        = item_pop && item_valid;
	assign item       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/core/pva_back.sv]
// Back end: voice state, oldest-release scan, release sequencing and output register.
module pva_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  pva_pkg::pva_item_t   item,
	output logic                 item_pop,
	input  logic                 out_stall,
	output logic                 out_valid,
	output pva_pkg::pva_result_t result
);
	import pva_pkg::*;

	pva_state_t         state_q;
	pva_state_t         state_d;
	pva_item_t          cur_q;
	logic [VIDX_W-1:0]  idx_q;
	logic               found_free_q;
	logic [VIDX_W-1:0]  free_pick_q;
	logic [STAMP_W-1:0] free_min_q;
	logic [VIDX_W-1:0]  all_pick_q;
	logic [STAMP_W-1:0] all_min_q;
	logic [VOICES-1:0]  mask_q;
	logic [VOICES-1:0]  in_use_q;
	logic [NOTE_W-1:0]  note_q [VOICES];
	logic [STAMP_W-1:0] stamp_q [VOICES];
	logic [STAMP_W-1:0] counter_q;
	logic               out_valid_q;
	pva_result_t        out_q;

	logic               out_free;
	logic [STAMP_W-1:0] stamp_rd;
	logic               free_take;
	logic               all_take;
	logic [VCNT_W-1:0]  idx_next_cnt;
	logic               scan_end;
	logic [VIDX_W-1:0]  on_pick;
	logic [VIDX_W-1:0]  off_pick;
	logic [VOICES-1:0]  off_bit;
	logic               off_last;
	logic [VOICES-1:0]  mask_new;
	logic               emit;
	logic               scan_step;
	logic               on_commit;
	logic               off_commit;
	logic               mask_load;
	pva_result_t        res;

	assign out_free     = !out_valid_q || !out_stall;
	assign stamp_rd     = stamp_q[idx_q];
	assign free_take    = !in_use_q[idx_q] && (!found_free_q || (stamp_rd < free_min_q));
	assign all_take     = (idx_q == '0) || (stamp_rd < all_min_q);
	assign idx_next_cnt = VCNT_W'(idx_q) + VCNT_W'(1);
	assign scan_end     = (idx_next_cnt == cur_q.count);
	assign on_pick      = found_free_q ? free_pick_q : all_pick_q;

	always_comb begin
		off_pick = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				off_pick = VIDX_W'(i);
			end
		end
		off_bit           = '0;
		off_bit[off_pick] = 1'b1;
		off_last          = ((mask_q & ~off_bit) == '0);
	end

	always_comb begin
		for (int i = 0; i < VOICES; i++) begin
			mask_new[i] = in_use_q[i] && (note_q[i] == cur_q.note) && (32'(cur_q.count) > i);
		end
	end

	always_comb begin
		state_d    = state_q;
		item_pop   = 1'b0;
		emit       = 1'b0;
		scan_step  = 1'b0;
		on_commit  = 1'b0;
		off_commit = 1'b0;
		mask_load  = 1'b0;
		res        = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					case (item.op)
						OP_ON:   state_d = ST_SCAN;
						OP_OFF:  state_d = ST_MASK;
						default: state_d = ST_SINGLE;
					endcase
				end
			end
			ST_SINGLE: begin
				res.single_voice = 1'b1;
				res.last         = 1'b1;
				if (cur_q.op == OP_SINGLE_OFF) begin
					res.event_kind = KIND_UP;
				end else begin
					res.event_kind   = KIND_DOWN;
					res.note_out     = cur_q.note;
					res.velocity_out = cur_q.velocity;
				end
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				scan_step = 1'b1;
				if (scan_end) begin
					state_d = ST_ON_EMIT;
				end
			end
			ST_ON_EMIT: begin
				res.event_kind   = KIND_DOWN;
				res.voice        = to_voice(on_pick);
				res.note_out     = cur_q.note;
				res.velocity_out = cur_q.velocity;
				res.last         = 1'b1;
				if (out_free) begin
					emit      = 1'b1;
					on_commit = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_MASK: begin
				mask_load = 1'b1;
				state_d   = (mask_new == '0) ? ST_IDLE : ST_OFF_EMIT;
			end
			ST_OFF_EMIT: begin
				res.event_kind = KIND_UP;
				res.voice      = to_voice(off_pick);
				res.last       = off_last;
				if (out_free) begin
					emit       = 1'b1;
					off_commit = 1'b1;
					if (off_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= '0;
			counter_q <= STAMP_W'(1);
			for (int i = 0; i < VOICES; i++) begin
				note_q[i]  <= '0;
				stamp_q[i] <= '0;
			end
		end else begin
			if (on_commit) begin
				in_use_q[on_pick] <= 1'b1;
				note_q[on_pick]   <= cur_q.note;
			end
			if (off_commit) begin
				in_use_q[off_pick] <= 1'b0;
				stamp_q[off_pick]  <= counter_q;
				// saturate at the top
				if (counter_q != '1) begin
					counter_q <= counter_q + STAMP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			cur_q        <= item;
			idx_q        <= '0;
			found_free_q <= 1'b0;
		end
		if (scan_step) begin
			if (free_take) begin
				found_free_q <= 1'b1;
				free_pick_q  <= idx_q;
				free_min_q   <= stamp_rd;
			end
			if (all_take) begin
				all_pick_q <= idx_q;
				all_min_q  <= stamp_rd;
			end
			idx_q <= idx_q + VIDX_W'(1);
		end
		if (mask_load) begin
			mask_q <= mask_new;
		end else if (off_commit) begin
			mask_q <= mask_q & ~off_bit;
		end
		if (emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

endmodule

[rtl/core/poly_voice_allocator.sv]
// Top level of the polyphonic voice allocator: front end, back end and port checks.
// Note-on: pop, then an oldest-release scan of n active voices at one voice per cycle,
//   then the ON_EMIT state loads the output register once the output is free.
// Note-off: pop, match, then one note-up per cycle per released voice unless stalled.
// Single-voice: one result. The front queue holds 2 transactions ahead of the back end.
// Reset: all voices free, notes and stamps zero, release counter one, block enabled,
//   multi-voice mode, 16 active voices.
module poly_voice_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [pva_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pva_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [pva_pkg::NOTE_W-1:0]    note,
	input  logic [pva_pkg::VEL_W-1:0]     velocity,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          event_kind,
	output logic [pva_pkg::VOICE_W-1:0]   voice,
	output logic                          single_voice,
	output logic [pva_pkg::NOTE_W-1:0]    note_out,
	output logic [pva_pkg::VEL_W-1:0]     velocity_out,
	output logic                          last
);
	import pva_pkg::*;

	logic        item_valid;
	pva_item_t   item;
	logic        item_pop;
	pva_result_t result;

	pva_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.note       (note),
		.velocity   (velocity),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	pva_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.result     (result)
	);

	assign event_kind   = result.event_kind;
	assign voice        = result.voice;
	assign single_voice = result.single_voice;
	assign note_out     = result.note_out;
	assign velocity_out = result.velocity_out;
	assign last         = result.last;

	a_single_voice_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && single_voice |-> (voice == '0) && last)
		else $error("single-voice transaction not on voice zero or not last");

	a_note_up_clear : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == KIND_UP) |-> (note_out == '0) && (velocity_out == '0))
		else $error("note-up transaction carries pitch or velocity");

	a_note_down_last : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == KIND_DOWN) |-> last)
		else $error("note-down transaction not marked last");

endmodule

[verif/voice_trigger_checker.sv]
// Checker for the voice allocator: tracks register writes, predicts voice triggers, compares them.
module voice_trigger_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [pva_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pva_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          command,
	input  logic [pva_pkg::NOTE_W-1:0]    note,
	input  logic [pva_pkg::VEL_W-1:0]     velocity,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          event_kind,
	input  logic [pva_pkg::VOICE_W-1:0]   voice,
	input  logic                          single_voice,
	input  logic [pva_pkg::NOTE_W-1:0]    note_out,
	input  logic [pva_pkg::VEL_W-1:0]     velocity_out,
	input  logic                          last,
	output int                            errors,
	output int                            pending,
	output int                            triggers_seen
);
	import pva_pkg::*;

	logic                en_q;
	logic                multi_q;
	logic [CFG_W-1:0]    active_q;
	logic                busy [VOICES];
	logic [NOTE_W-1:0]   held_note [VOICES];
	logic [STAMP_W-1:0]  rel_stamp [VOICES];
	logic [STAMP_W-1:0]  rel_count;
	pva_result_t         expected_triggers [$];

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
		end
	endtask

	task automatic predict_triggers(input logic cmd, input logic [NOTE_W-1:0] nt,
			input logic [VEL_W-1:0] vel);
		int          n;
		int          pick;
		bit          found;
		bit          have_prev;
		pva_result_t trig;
		pva_result_t prev;
		if (!en_q)
			return;
		trig = '0;
		trig.last = 1'b1;
		if (!multi_q) begin
			trig.single_voice = 1'b1;
			if (cmd == CMD_NOTE_ON) begin
				trig.event_kind   = KIND_DOWN;
				trig.note_out     = nt;
				trig.velocity_out = vel;
			end else begin
				trig.event_kind = KIND_UP;
			end
			expected_triggers.push_back(trig);
			return;
		end
		n = int'(active_q);
		if (n < 1)
			n = 1;
		if (n > VOICES)
			n = VOICES;
		if (cmd == CMD_NOTE_ON) begin
			found = 1'b0;
			pick  = 0;
			for (int i = 0; i < n; i++) begin
				if (!busy[i] && (!found || rel_stamp[i] < rel_stamp[pick])) begin
					pick  = i;
					found = 1'b1;
				end
			end
			// steal the oldest release when every active voice is busy
			if (!found) begin
				pick = 0;
				for (int i = 1; i < n; i++)
					if (rel_stamp[i] < rel_stamp[pick])
						pick = i;
			end
			busy[pick]        = 1'b1;
			held_note[pick]   = nt;
			trig.event_kind   = KIND_DOWN;
			trig.voice        = pick[VOICE_W-1:0];
			trig.note_out     = nt;
			trig.velocity_out = vel;
			expected_triggers.push_back(trig);
			return;
		end
		have_prev = 1'b0;
		prev      = '0;
		for (int i = 0; i < n; i++) begin
			if (busy[i] && held_note[i] == nt) begin
				busy[i]      = 1'b0;
				rel_stamp[i] = rel_count;
				if (rel_count != '1)
					rel_count++;
				if (have_prev)
					expected_triggers.push_back(prev);
				prev            = '0;
				prev.event_kind = KIND_UP;
				prev.voice      = i[VOICE_W-1:0];
				have_prev       = 1'b1;
			end
		end
		if (have_prev) begin
			prev.last = 1'b1;
			expected_triggers.push_back(prev);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		pva_result_t got;
		pva_result_t want;
		if (!arst_n) begin
			en_q      = 1'b1;
			multi_q   = 1'b1;
			active_q  = CFG_W'(ACTIVE_RESET);
			rel_count = STAMP_W'(1);
			for (int i = 0; i < VOICES; i++) begin
				busy[i]      = 1'b0;
				held_note[i] = '0;
				rel_stamp[i] = '0;
			end
			expected_triggers.delete();
			errors        = 0;
			triggers_seen = 0;
			pending       = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {event_kind, voice, single_voice, note_out, velocity_out, last};
				triggers_seen++;
				if (expected_triggers.size() == 0) begin
					errors++;
					$display("%0t: unexpected voice trigger, expected none, got %p",
						$time, got);
				end else begin
					want = expected_triggers.pop_front();
					check_field("event_kind", int'(want.event_kind), int'(got.event_kind));
					check_field("voice", int'(want.voice), int'(got.voice));
					check_field("single_voice", int'(want.single_voice),
						int'(got.single_voice));
					check_field("note_out", int'(want.note_out), int'(got.note_out));
					check_field("velocity_out", int'(want.velocity_out),
						int'(got.velocity_out));
					check_field("last", int'(want.last), int'(got.last));
				end
			end
			if (in_valid && !in_stall)
				predict_triggers(command, note, velocity);
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_ENABLED: en_q = cfg_data[0];
					CFG_MULTI:   multi_q = cfg_data[0];
					CFG_ACTIVE:  active_q = cfg_data;
					default: ;
				endcase
			end
			pending = expected_triggers.size();
		end
	end

endmodule

[verif/poly_voice_allocator_tb.sv]
// Testbench top for the voice allocator: clock, reset, note event stimulus and verdict.
module poly_voice_allocator_tb;
	import pva_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 80;
	localparam int HOLD_OFF_CYCLES = 400;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 command;
	logic [NOTE_W-1:0]    note;
	logic [VEL_W-1:0]     velocity;
	logic                 out_valid;
	logic                 out_stall;
	logic                 event_kind;
	logic [VOICE_W-1:0]   voice;
	logic                 single_voice;
	logic [NOTE_W-1:0]    note_out;
	logic [VEL_W-1:0]     velocity_out;
	logic                 last;

	int                   errors;
	int                   pending;
	int                   triggers_seen;
	int                   events_sent;
	int                   settings_used;
	int                   cycles;
	int                   hold_requests;
	bit                   quiet;
	logic [NOTE_W-1:0]    note_pool [8];

	poly_voice_allocator i_dut (.*);

	voice_trigger_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("poly_voice_allocator test failed");
		$finish;
	end

	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 24);
			end
		end
	end

	task automatic send_event(input logic cmd, input logic [NOTE_W-1:0] nt,
			input logic [VEL_W-1:0] vel);
		while (!quiet && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		note     <= nt;
		velocity <= vel;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		events_sent++;
	endtask

	// drop valid, wait for every trigger, then let silent transactions drain
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_registers(input logic en, input logic multi,
			input logic [CFG_W-1:0] active);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_ENABLED;
		cfg_data  <= {4'($urandom), en};
		@(negedge clk);
		cfg_index <= CFG_MULTI;
		cfg_data  <= {4'($urandom), multi};
		@(negedge clk);
		cfg_index <= CFG_ACTIVE;
		cfg_data  <= active;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	task automatic random_events(input int count, input int on_pct);
		logic              cmd;
		logic [NOTE_W-1:0] nt;
		for (int k = 0; k < 8; k++)
			note_pool[k] = NOTE_W'($urandom);
		note_pool[0] = $urandom_range(1) ? NOTE_W'(0) : NOTE_W'(127);
		for (int i = 0; i < count; i++) begin
			cmd = ($urandom_range(99) < on_pct) ? CMD_NOTE_ON : CMD_NOTE_OFF;
			nt  = ($urandom_range(3) == 0) ? NOTE_W'($urandom)
				: note_pool[3'($urandom_range(7))];
			send_event(cmd, nt, VEL_W'($urandom));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = CFG_ENABLED;
		cfg_data      = '0;
		in_valid      = 1'b0;
		command       = CMD_NOTE_ON;
		note          = '0;
		velocity      = '0;
		quiet         = 1'b0;
		hold_requests = 0;
		events_sent   = 0;
		settings_used = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: field extremes, shared notes, unmatched release, full pool and steal
		send_event(CMD_NOTE_ON, NOTE_W'(0), VEL_W'(0));
		send_event(CMD_NOTE_ON, NOTE_W'(127), VEL_W'(127));
		repeat (3) send_event(CMD_NOTE_ON, NOTE_W'(60), VEL_W'($urandom));
		send_event(CMD_NOTE_OFF, NOTE_W'(60), VEL_W'(0));
		send_event(CMD_NOTE_OFF, NOTE_W'(99), VEL_W'(127));
		repeat (14) send_event(CMD_NOTE_ON, NOTE_W'(64), VEL_W'($urandom));
		send_event(CMD_NOTE_ON, NOTE_W'(5), VEL_W'(5));
		send_event(CMD_NOTE_OFF, NOTE_W'(64), VEL_W'(127));
		settle();

		quiet = 1'b1;
		set_registers(1'b1, 1'b1, CFG_W'(16));
		random_events(40, 60);
		settle();
		quiet = 1'b0;

		set_registers(1'b1, 1'b1, CFG_W'(1));
		random_events(15, 50);
		settle();

		set_registers(1'b1, 1'b1, CFG_W'(0));
		random_events(10, 50);
		settle();

		set_registers(1'b1, 1'b1, CFG_W'(31));
		random_events(20, 55);
		settle();

		set_registers(1'b1, 1'b1, CFG_W'(4));
		random_events(20, 55);
		settle();

		set_registers(1'b1, 1'b0, CFG_W'($urandom));
		random_events(15, 50);
		settle();

		set_registers(1'b0, 1'($urandom), CFG_W'($urandom));
		random_events(10, 50);
		settle();

		// hold the output back so the front queue fills and stalls its input
		set_registers(1'b1, 1'b1, CFG_W'(17));
		hold_requests++;
		random_events(20, 60);
		settle();

		set_registers(1'b1, 1'b1, CFG_W'($urandom_range(1, 16)));
		random_events(40, 55);
		settle();

		$display("Sent %0d note events over %0d register settings, %0d voice triggers checked.",
			events_sent, settings_used, triggers_seen);
		$display("Covered stealing, multi-voice release, single-voice, disabled, clamped counts.");
		if (errors == 0) begin
			$display("poly_voice_allocator test passed");
		end else begin
			$display("poly_voice_allocator test failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/pva_pkg.sv
rtl/core/pva_front.sv
rtl/core/pva_back.sv
rtl/core/poly_voice_allocator.sv
verif/voice_trigger_checker.sv
verif/poly_voice_allocator_tb.sv
